[rtl/core/kcl_pkg.sv]
// Shared types, codes and constants of the keypad code lock.
`timescale 1ns / 1ps

package kcl_pkg;

   localparam int CODE_LENGTH = 5;
   localparam int CNT_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CODE_LENGTH - 1);

   localparam logic [7:0] KEY_PLUS  = 8'h2B;
   localparam logic [7:0] KEY_MINUS = 8'h2D;

   localparam logic MODE_KEY  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WRONG     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_TICKS = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_TICKS    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_TICKS   = CSR_IDX_W'(3);

   localparam logic [2:0]  RST_MAX_WRONG     = 3'd5;
   localparam logic [15:0] RST_LOCKOUT_TICKS = 16'd30;
   localparam logic [15:0] RST_OPEN_TICKS    = 16'd20;
   localparam logic [15:0] RST_CLOSE_TICKS   = 16'd20;

   localparam logic [1:0] MOTOR_STOP  = 2'd0;
   localparam logic [1:0] MOTOR_OPEN  = 2'd1;
   localparam logic [1:0] MOTOR_CLOSE = 2'd2;

   localparam logic [2:0] PCODE_SET     = 3'd0;
   localparam logic [2:0] PCODE_CONFIRM = 3'd1;
   localparam logic [2:0] PCODE_CHOOSE  = 3'd2;
   localparam logic [2:0] PCODE_VERIFY  = 3'd3;
   localparam logic [2:0] PCODE_OPEN    = 3'd4;
   localparam logic [2:0] PCODE_CLOSE   = 3'd5;
   localparam logic [2:0] PCODE_LOCK    = 3'd6;

   typedef enum logic [6:0] {
      PH_SET     = 7'b0000001,
      PH_CONFIRM = 7'b0000010,
      PH_CHOOSE  = 7'b0000100,
      PH_VERIFY  = 7'b0001000,
      PH_OPEN    = 7'b0010000,
      PH_CLOSE   = 7'b0100000,
      PH_LOCK    = 7'b1000000
   } kcl_phase_type;

   typedef enum logic [3:0] {
      EV_NONE       = 4'd0,
      EV_DIGIT      = 4'd1,
      EV_FIRST_DONE = 4'd2,
      EV_MISMATCH   = 4'd3,
      EV_STORED     = 4'd4,
      EV_BAD_CHOICE = 4'd5,
      EV_CHOICE     = 4'd6,
      EV_WRONG      = 4'd7,
      EV_CORRECT    = 4'd8,
      EV_LOCKOUT    = 4'd9,
      EV_UNLOCK     = 4'd10,
      EV_CLOSING    = 4'd11,
      EV_CLOSED     = 4'd12
   } kcl_event_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] key_code;
   } kcl_req_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [1:0]  motor_drive;
      logic [3:0]  event_code;
      logic [2:0]  digits_entered;
      logic [2:0]  wrong_count;
      logic [15:0] ticks_left;
   } kcl_rsp_type;

   typedef struct packed {
      logic [2:0]  max_wrong;
      logic [15:0] lockout_ticks;
      logic [15:0] open_ticks;
      logic [15:0] close_ticks;
   } kcl_cfg_type;

   // key store commands from the controller
   typedef struct packed {
      logic take;
      logic save_first;
      logic save_code;
   } kcl_key_cmd_type;

   // entry compare results, with the incoming key in its slot
   typedef struct packed {
      logic first_eq;
      logic code_eq;
   } kcl_cmp_type;

   function automatic logic [2:0] phase_code(kcl_phase_type p);
      logic [2:0] code;
      case (p)
         PH_SET:     code = PCODE_SET;
         PH_CONFIRM: code = PCODE_CONFIRM;
         PH_CHOOSE:  code = PCODE_CHOOSE;
         PH_VERIFY:  code = PCODE_VERIFY;
         PH_OPEN:    code = PCODE_OPEN;
         PH_CLOSE:   code = PCODE_CLOSE;
         PH_LOCK:    code = PCODE_LOCK;
         default:    code = PCODE_SET;
      endcase
      return code;
   endfunction

endpackage

[rtl/core/kcl_keystore.sv]
// Key entry, first entry and stored code registers with parallel compare.
`timescale 1ns / 1ps

module kcl_keystore import kcl_pkg::*; (
   input  logic             clock,
   input  logic             fire,
   input  logic [7:0]       key_code,
   input  logic [CNT_W-1:0] count,
   input  kcl_key_cmd_type  cmd,
   output kcl_cmp_type      cmp
);

   logic [7:0] entry_ff  [CODE_LENGTH];
   logic [7:0] first_ff  [CODE_LENGTH];
   logic [7:0] stored_ff [CODE_LENGTH];
   logic [7:0] entry_in  [CODE_LENGTH];

   // entry as it stands once the incoming key is placed
   always_comb begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
         entry_in[i] = (count == CNT_W'(i)) ? key_code : entry_ff[i];
      end
   end

   always_comb begin
      cmp.first_eq = 1'b1;
      cmp.code_eq  = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (entry_in[i] != first_ff[i]) cmp.first_eq = 1'b0;
         if (entry_in[i] != stored_ff[i]) cmp.code_eq = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && cmd.take) entry_ff <= entry_in;
      if (fire && cmd.save_first) first_ff <= entry_in;
      if (fire && cmd.save_code) stored_ff <= entry_in;
   end

endmodule

[rtl/core/kcl_ctrl.sv]
// Phase control, counters and tick timer of the code lock.
`timescale 1ns / 1ps

module kcl_ctrl import kcl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  kcl_req_type      req,
   input  kcl_cfg_type      cfg,
   input  kcl_cmp_type      cmp,
   output kcl_key_cmd_type  cmd,
   output logic [CNT_W-1:0] count,
   output kcl_rsp_type      rsp
);

   kcl_phase_type    phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]       wrong_ff, wrong_in;
   logic             open_ff, open_in;
   logic [15:0]      timer_ff, timer_in;
   kcl_event_type    event_in;
   logic             last_key;
   logic [2:0]       wrong_inc;
   logic [15:0]      timer_dec;
   logic [1:0]       motor;

   assign count     = count_ff;
   assign last_key  = (count_ff == LAST_IDX);
   assign wrong_inc = wrong_ff + 3'd1;
   assign timer_dec = timer_ff - 16'(timer_ff != 16'd0);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      wrong_in = wrong_ff;
      open_in  = open_ff;
      timer_in = timer_ff;
      event_in = EV_NONE;
      cmd      = '0;
      if (req.mode == MODE_KEY) begin
         case (phase_ff)
            PH_SET: begin
               cmd.take = 1'b1;
               if (last_key) begin
                  count_in       = '0;
                  cmd.save_first = 1'b1;
                  phase_in       = PH_CONFIRM;
                  event_in       = EV_FIRST_DONE;
               end else begin
                  count_in = count_ff + 1'b1;
                  event_in = EV_DIGIT;
               end
            end
            PH_CONFIRM: begin
               cmd.take = 1'b1;
               if (last_key) begin
                  count_in = '0;
                  if (cmp.first_eq) begin
                     cmd.save_code = 1'b1;
                     phase_in      = PH_CHOOSE;
                     event_in      = EV_STORED;
                  end else begin
                     phase_in = PH_SET;
                     event_in = EV_MISMATCH;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
                  event_in = EV_DIGIT;
               end
            end
            PH_CHOOSE: begin
               count_in = '0;
               if (req.key_code == KEY_PLUS || req.key_code == KEY_MINUS) begin
                  open_in  = (req.key_code == KEY_PLUS);
                  phase_in = PH_VERIFY;
                  event_in = EV_CHOICE;
               end else begin
                  event_in = EV_BAD_CHOICE;
               end
            end
            PH_VERIFY: begin
               cmd.take = 1'b1;
               if (last_key) begin
                  count_in = '0;
                  if (cmp.code_eq) begin
                     event_in = EV_CORRECT;
                     if (open_ff) begin
                        phase_in = PH_OPEN;
                        timer_in = cfg.open_ticks;
                     end else begin
                        phase_in = PH_SET;
                     end
                  end else if (wrong_inc >= cfg.max_wrong) begin
                     wrong_in = '0;
                     phase_in = PH_LOCK;
                     timer_in = cfg.lockout_ticks;
                     event_in = EV_LOCKOUT;
                  end else begin
                     wrong_in = wrong_inc;
                     event_in = EV_WRONG;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
                  event_in = EV_DIGIT;
               end
            end
            default: ;
         endcase
      end else if (phase_ff inside {PH_OPEN, PH_CLOSE, PH_LOCK}) begin
         timer_in = timer_dec;
         if (timer_dec == 16'd0) begin
            if (phase_ff == PH_OPEN) begin
               phase_in = PH_CLOSE;
               timer_in = cfg.close_ticks;
               event_in = EV_CLOSING;
            end else begin
               count_in = '0;
               phase_in = PH_CHOOSE;
               event_in = (phase_ff == PH_CLOSE) ? EV_CLOSED : EV_UNLOCK;
            end
         end
      end
   end

   always_comb begin
      case (phase_in)
         PH_OPEN:  motor = MOTOR_OPEN;
         PH_CLOSE: motor = MOTOR_CLOSE;
         default:  motor = MOTOR_STOP;
      endcase
   end

   always_comb begin
      rsp.phase          = phase_code(phase_in);
      rsp.motor_drive    = motor;
      rsp.event_code     = event_in;
      rsp.digits_entered = 3'(count_in);
      rsp.wrong_count    = wrong_in;
      rsp.ticks_left     = timer_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SET;
         count_ff <= '0;
         wrong_ff <= '0;
         open_ff  <= 1'b0;
         timer_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         wrong_ff <= wrong_in;
         open_ff  <= open_in;
         timer_ff <= timer_in;
      end
   end

   entry_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_IDX)
      else $error("entry count beyond code length");

   lockout_clears_wrong: assert property (@(posedge clock) disable iff (reset)
      fire && event_in == EV_LOCKOUT |=> phase_ff == PH_LOCK && wrong_ff == 3'd0)
      else $error("lockout did not clear wrong count");

   key_ignored_in_motion: assert property (@(posedge clock) disable iff (reset)
      fire && req.mode == MODE_KEY && (phase_ff == PH_OPEN || phase_ff == PH_CLOSE ||
      phase_ff == PH_LOCK) |=> $stable(phase_ff) && $stable(timer_ff))
      else $error("key changed state while moving or locked out");

endmodule

[rtl/core/keypad_code_lock_controller.sv]
// Top level of the keypad code lock: word registers, config registers, core.
//
//   channel  direction  handshake                 word
//   req_     in         req_valid / req_ready     req_data  (kcl_req_type)
//   rsp_     out        rsp_valid / rsp_ready     rsp_data  (kcl_rsp_type)
//   csr_     in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One word per cycle sustained while rsp_ready holds: input register, then all decode
// and code compare in one pass into the output register, whose valid is rsp_valid.
// Synchronous reset puts the lock in code setting with the config defaults.
// A stalled output holds its word; the input register still takes one more word.
// csr writes are always ready and take effect on the next word processed.
`timescale 1ns / 1ps

module keypad_code_lock_controller import kcl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kcl_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kcl_rsp_type          rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   kcl_req_type      req_ff;
   logic             req_valid_ff;
   kcl_rsp_type      rsp_ff, rsp_in;
   logic             rsp_valid_ff;
   kcl_cfg_type      cfg_ff;
   logic             fire;
   kcl_key_cmd_type  cmd;
   kcl_cmp_type      cmp;
   logic [CNT_W-1:0] count;

   assign fire      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) req_valid_ff <= req_valid;
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      if (fire) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_wrong     <= RST_MAX_WRONG;
         cfg_ff.lockout_ticks <= RST_LOCKOUT_TICKS;
         cfg_ff.open_ticks    <= RST_OPEN_TICKS;
         cfg_ff.close_ticks   <= RST_CLOSE_TICKS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_WRONG:     cfg_ff.max_wrong     <= csr_wdata[2:0];
            CSR_LOCKOUT_TICKS: cfg_ff.lockout_ticks <= csr_wdata;
            CSR_OPEN_TICKS:    cfg_ff.open_ticks    <= csr_wdata;
            CSR_CLOSE_TICKS:   cfg_ff.close_ticks   <= csr_wdata;
            default: ;
         endcase
      end
   end

   kcl_keystore u_keystore (
      .clock    (clock),
      .fire     (fire),
      .key_code (req_ff.key_code),
      .count    (count),
      .cmd      (cmd),
      .cmp      (cmp)
   );

   kcl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .cmp   (cmp),
      .cmd   (cmd),
      .count (count),
      .rsp   (rsp_in)
   );

   accepted_word_held: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> req_valid_ff)
      else $error("accepted word not held in input register");

   processed_word_shown: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed word not presented");

   no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !fire)
      else $error("output word overwritten while stalled");

endmodule
